/* design/lrg_pkg.sv */
// Shared types, constants and state encoding for the linear ramp generator.
`timescale 1ns / 1ps
`default_nettype none

package lrg_pkg;

   // Field widths
   localparam int LEVEL_W          = 32;
   localparam int SECS_W           = 24;
   localparam int RATE_W           = 18;
   localparam int ACC_W            = 48;
   localparam int LEVEL_EXTRA_BITS = ACC_W - LEVEL_W;
   localparam int DUR_W            = 32;
   localparam int STEP_W           = DUR_W - 1;
   localparam int PROD_W           = RATE_W + SECS_W;

   // Ramp time fraction bits (default Q8.16)
   localparam int FRACTION_BITS_DEF = 16;

   // Increment divider: one quotient bit per cycle
   localparam int DIV_STEPS = ACC_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Register file
   localparam int                  CSR_ADDR_W   = 3;
   localparam int                  CSR_DATA_W   = 32;
   localparam int                  CSR_IDX_W    = CSR_ADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_RATE = '0;
   localparam logic [RATE_W-1:0]   RATE_RESET   = RATE_W'(48000);

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL,
      ST_SEG,
      ST_DIV,
      ST_INC,
      ST_EMIT,
      ST_ADV
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;      // latch the input word
      logic mul;       // rate * seconds
      logic seg;       // segment start: duration, level, divider setup
      logic div_step;  // one restoring divider step
      logic inc_set;   // sign and saturate the quotient into the increment
      logic emit;      // load the output register
      logic advance;   // ramp step or end-of-segment handling
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic dur_zero;
      logic dur_pos;
      logic step_lt;
      logic loop;
      logic div_last;
      logic out_room;
   } status_type;

endpackage

`default_nettype wire

/* design/lrg_csr.sv */
// APB-style register file holding the sample rate.
`timescale 1ns / 1ps
`default_nettype none

module lrg_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [lrg_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [lrg_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [lrg_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                  csr_pready,
   output logic      [lrg_pkg::RATE_W-1:0]       sample_rate
);
   import lrg_pkg::*;

   logic [RATE_W-1:0]    rate_ff;
   logic [RATE_W-1:0]    rate_in;
   logic [CSR_IDX_W-1:0] idx;
   logic                 wr_en;

   assign idx        = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // Write decode
   always_comb begin
      rate_in = rate_ff;
      if (wr_en && idx == CSR_IDX_RATE) begin
         rate_in = csr_pwdata[RATE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= RATE_RESET;
      end else begin
         rate_ff <= rate_in;
      end
   end

   // Read mux
   always_comb begin
      csr_prdata = '0;
      if (idx == CSR_IDX_RATE) begin
         csr_prdata = CSR_DATA_W'(rate_ff);
      end
   end

   assign sample_rate = rate_ff;

endmodule

`default_nettype wire

/* design/lrg_ctrl.sv */
// Sequencer for one tick: segment start, divide, emit, advance.
`timescale 1ns / 1ps
`default_nettype none

module lrg_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire lrg_pkg::status_type   status,
   output lrg_pkg::cmd_type           cmd
);
   import lrg_pkg::*;

   state_type state_ff, state_in;
   logic      post_ff, post_in;        // segment start comes from loop at end of tick
   logic      started_ff, started_in;  // a segment already started this tick

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         post_ff    <= 1'b0;
         started_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         post_ff    <= post_in;
         started_ff <= started_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      post_in    = post_ff;
      started_in = started_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load   = 1'b1;
               started_in = 1'b0;
               state_in   = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.dur_zero) begin
               post_in    = 1'b0;
               started_in = 1'b1;
               state_in   = ST_MUL;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SEG;
         end
         ST_SEG: begin
            cmd.seg  = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // short segments take a zero increment, no divide needed
            if (!status.dur_pos) begin
               state_in = ST_INC;
            end else begin
               cmd.div_step = 1'b1;
               if (status.div_last) begin
                  state_in = ST_INC;
               end
            end
         end
         ST_INC: begin
            cmd.inc_set = 1'b1;
            state_in    = post_ff ? ST_IDLE : ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_room) begin
               cmd.emit = 1'b1;
               state_in = ST_ADV;
            end
         end
         ST_ADV: begin
            cmd.advance = 1'b1;
            // a second start in the same tick would give identical values
            if (!status.step_lt && status.loop && !started_ff) begin
               post_in    = 1'b1;
               started_in = 1'b1;
               state_in   = ST_MUL;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

/* design/lrg_dp.sv */
// Ramp datapath: time product, serial increment divider, accumulator, output register.
`timescale 1ns / 1ps
`default_nettype none

module lrg_dp #(
   parameter int FRACTION_BITS = lrg_pkg::FRACTION_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire lrg_pkg::cmd_type                  cmd,
   output lrg_pkg::status_type                    status,
   input  wire logic [lrg_pkg::RATE_W-1:0]        sample_rate,
   input  wire logic signed [lrg_pkg::LEVEL_W-1:0] start_level,
   input  wire logic signed [lrg_pkg::LEVEL_W-1:0] end_level,
   input  wire logic [lrg_pkg::SECS_W-1:0]        ramp_seconds,
   input  wire logic                              loop_enable,
   input  wire logic                              restart,
   output logic signed [lrg_pkg::LEVEL_W-1:0]     level,
   output logic                                   level_valid,
   input  wire logic                              level_ready
);
   import lrg_pkg::*;

   localparam logic [PROD_W-1:0] COUNT_MAX = PROD_W'(32'h7FFF_FFFF);
   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   // Latched input word
   logic signed [LEVEL_W-1:0] from_ff, to_ff;
   logic [SECS_W-1:0]         secs_ff;
   logic                      loop_ff;

   // Ramp state
   logic signed [DUR_W-1:0] dur_ff, dur_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ACC_W-1:0] inc_ff, inc_in;
   logic [PROD_W-1:0]       prod_ff;

   // Divider
   logic [DUR_W-1:0]     rem_ff, rem_in;
   logic [ACC_W-1:0]     quo_ff, quo_in;
   logic [STEP_W-1:0]    dvs_ff, dvs_in;
   logic                 neg_ff, neg_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;

   // Output register
   logic signed [LEVEL_W-1:0] out_ff;
   logic                      out_vld_ff, out_vld_in;

   // Combinational helpers
   logic [PROD_W-1:0]       count;
   logic [STEP_W-1:0]       count_sat;
   logic signed [DUR_W-1:0] dur_new;
   logic [LEVEL_W:0]        diff;
   logic [LEVEL_W:0]        diff_mag;
   logic [DUR_W-1:0]        rem_sh;
   logic [DUR_W:0]          rem_sub;
   logic [ACC_W:0]          sum;
   logic signed [ACC_W-1:0] sum_sat;
   logic signed [ACC_W-1:0] quo_signed;
   logic                    dur_pos;
   logic                    step_lt;
   logic                    out_room;

   // Segment start arithmetic
   assign count     = prod_ff >> FRACTION_BITS;
   assign count_sat = (count > COUNT_MAX) ? STEP_W'(COUNT_MAX) : count[STEP_W-1:0];
   assign dur_new   = {1'b0, count_sat} - DUR_W'(1);
   assign diff      = {to_ff[LEVEL_W-1], to_ff} - {from_ff[LEVEL_W-1], from_ff};
   assign diff_mag  = diff[LEVEL_W] ? (~diff + 1'b1) : diff;

   // Restoring divider step
   assign rem_sh  = {rem_ff[DUR_W-2:0], quo_ff[ACC_W-1]};
   assign rem_sub = {1'b0, rem_sh} - {2'b00, dvs_ff};

   // Quotient sign and saturation
   always_comb begin
      if (neg_ff) begin
         quo_signed = quo_ff[ACC_W-1] ? ACC_MIN : -$signed(quo_ff);
      end else begin
         quo_signed = quo_ff[ACC_W-1] ? ACC_MAX : $signed(quo_ff);
      end
   end

   // Saturating accumulator add
   assign sum = {acc_ff[ACC_W-1], acc_ff} + {inc_ff[ACC_W-1], inc_ff};
   always_comb begin
      if (sum[ACC_W] != sum[ACC_W-1]) begin
         sum_sat = sum[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
         sum_sat = $signed(sum[ACC_W-1:0]);
      end
   end

   assign dur_pos  = !dur_ff[DUR_W-1] && (dur_ff != '0);
   assign step_lt  = !dur_ff[DUR_W-1] && (step_ff < dur_ff[STEP_W-1:0]);
   assign out_room = !out_vld_ff || level_ready;

   // Next state of the ramp and divider registers
   always_comb begin
      dur_in  = dur_ff;
      step_in = step_ff;
      acc_in  = acc_ff;
      inc_in  = inc_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      if (cmd.load && restart) begin
         dur_in  = '0;
         step_in = '0;
      end
      if (cmd.seg) begin
         dur_in = dur_new;
         acc_in = {from_ff, {LEVEL_EXTRA_BITS{1'b0}}};
         rem_in = '0;
         quo_in = {diff_mag[LEVEL_W-1:0], {LEVEL_EXTRA_BITS{1'b0}}};
         dvs_in = dur_new[STEP_W-1:0];
         neg_in = diff[LEVEL_W];
         cnt_in = '0;
      end
      if (cmd.div_step) begin
         if (!rem_sub[DUR_W]) begin
            rem_in = rem_sub[DUR_W-1:0];
         end else begin
            rem_in = rem_sh;
         end
         quo_in = {quo_ff[ACC_W-2:0], !rem_sub[DUR_W]};
         cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.inc_set) begin
         inc_in = dur_pos ? quo_signed : '0;
      end
      if (cmd.advance) begin
         if (step_lt) begin
            acc_in  = sum_sat;
            step_in = step_ff + 1'b1;
         end else if (loop_ff) begin
            step_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dur_ff  <= '0;
         step_ff <= '0;
         acc_ff  <= '0;
         inc_ff  <= '0;
      end else begin
         dur_ff  <= dur_in;
         step_ff <= step_in;
         acc_ff  <= acc_in;
         inc_ff  <= inc_in;
      end
   end

   // Divider working registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
   end

   // Input word and time product
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         from_ff <= start_level;
         to_ff   <= end_level;
         secs_ff <= ramp_seconds;
         loop_ff <= loop_enable;
      end
      if (cmd.mul) begin
         prod_ff <= PROD_W'(sample_rate) * PROD_W'(secs_ff);
      end
   end

   // Output register
   always_comb begin
      out_vld_in = out_vld_ff;
      if (cmd.emit) begin
         out_vld_in = 1'b1;
      end else if (level_ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_ff <= acc_ff[ACC_W-1:LEVEL_EXTRA_BITS];
      end
   end

   assign level       = out_ff;
   assign level_valid = out_vld_ff;

   assign status.dur_zero = (dur_ff == '0);
   assign status.dur_pos  = dur_pos;
   assign status.step_lt  = step_lt;
   assign status.loop     = loop_ff;
   assign status.div_last = (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));
   assign status.out_room = out_room;

endmodule

`default_nettype wire

/* design/linear_ramp_generator_core.sv */
// Linear ramp envelope generator top level: one channel, one level word per tick.
// Sequence: accept, check, emit, advance while a segment runs; a tick that starts a segment
// first runs multiply, setup, a 48-step restoring divider and sign fix. Emit waits for room.
// Ticks: one at a time; a segment started at the head of the tick or reloaded at its end adds
// multiply, setup and divide, and the serial increment divider sets the worst case.
// Reset: synchronous, active high; clears accumulator, increment, step, duration and output valid,
// sample rate returns to 48000. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module linear_ramp_generator_core #(
   parameter int FRACTION_BITS = lrg_pkg::FRACTION_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // req_tdata: start_level[31:0], end_level[63:32], ramp_seconds[87:64]
   input  wire logic [87:0]                    req_tdata,
   // req_tuser: loop_enable[0], restart[1]
   input  wire logic [1:0]                     req_tuser,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // rsp_tdata: level[31:0]
   output logic [lrg_pkg::LEVEL_W-1:0]         rsp_tdata,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [lrg_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [lrg_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [lrg_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                csr_pready
);
   import lrg_pkg::*;

   cmd_type                   cmd;
   status_type                status;
   logic [RATE_W-1:0]         sample_rate;
   logic signed [LEVEL_W-1:0] level;

   lrg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .sample_rate (sample_rate)
   );

   lrg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lrg_dp #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .sample_rate  (sample_rate),
      .start_level  (req_tdata[31:0]),
      .end_level    (req_tdata[63:32]),
      .ramp_seconds (req_tdata[87:64]),
      .loop_enable  (req_tuser[0]),
      .restart      (req_tuser[1]),
      .level        (level),
      .level_valid  (rsp_tvalid),
      .level_ready  (rsp_tready)
   );

   assign rsp_tdata = level;

endmodule

`default_nettype wire

/* design/lrg_checker.sv */
// Port-level assertions for the ramp generator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module lrg_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_tvalid,
   input wire logic                           req_tready,
   input wire logic [lrg_pkg::LEVEL_W-1:0]    rsp_tdata,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic                           csr_psel,
   input wire logic                           csr_penable,
   input wire logic                           csr_pwrite,
   input wire logic [lrg_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input wire logic [lrg_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input wire logic [lrg_pkg::CSR_DATA_W-1:0] csr_prdata,
   input wire logic                           csr_pready
);
   import lrg_pkg::*;

   logic rate_wr;
   assign rate_wr = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                    (csr_paddr[CSR_ADDR_W-1:2] == CSR_IDX_RATE);

   // A stalled level word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("level word changed while stalled");

   // One tick at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted while a tick is in progress");

   // A new level word only appears while a tick is being worked
   a_rsp_from_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !req_tready)
      else $error("level word without a tick in progress");

   // Sample rate reads back what was written
   a_rate_readback: assert property (@(posedge clock) disable iff (reset)
      rate_wr |=> (csr_paddr[CSR_ADDR_W-1:2] != CSR_IDX_RATE) ||
                  (csr_prdata == CSR_DATA_W'($past(csr_pwdata[RATE_W-1:0]))))
      else $error("sample rate readback mismatch");

endmodule

bind linear_ramp_generator_core lrg_checker u_lrg_checker (
   .clock       (clock),
   .reset       (reset),
   .req_tvalid  (req_tvalid),
   .req_tready  (req_tready),
   .rsp_tdata   (rsp_tdata),
   .rsp_tvalid  (rsp_tvalid),
   .rsp_tready  (rsp_tready),
   .csr_psel    (csr_psel),
   .csr_penable (csr_penable),
   .csr_pwrite  (csr_pwrite),
   .csr_paddr   (csr_paddr),
   .csr_pwdata  (csr_pwdata),
   .csr_prdata  (csr_prdata),
   .csr_pready  (csr_pready)
);

`default_nettype wire
